FILE: design/fdc_pkg.sv
// Shared constants, codes and control structs for the floppy drive controller.
`timescale 1ns / 1ps
`default_nettype none

package fdc_pkg;

  localparam int SECTORS_PER_TRACK = 18;
  localparam int TOTAL_SECTORS     = 1440;

  localparam int TRACKS   = (TOTAL_SECTORS + SECTORS_PER_TRACK - 1) / SECTORS_PER_TRACK;

  localparam int OP_W     = 3;
  localparam int WORD_W   = 16;
  localparam int BLOCK_W  = 9;
  localparam int TRACK_W  = 9;
  localparam int TT_W     = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int TS_W     = 11;
  localparam int HS_W     = (SECTORS_PER_TRACK > 1) ? $clog2(SECTORS_PER_TRACK) : 1;
  localparam int DRV_W    = 3;
  localparam int ERR_W    = 3;

  localparam logic [TRACK_W-1:0] HEAD_TRACK_RESET = TRACK_W'(400);

  localparam int STEP_ADV = 73 % SECTORS_PER_TRACK;
  localparam int IDLE_ADV = 1535 % SECTORS_PER_TRACK;

  localparam int RECIP_SH = 20;
  localparam int RECIP    = ((1 << RECIP_SH) + SECTORS_PER_TRACK - 1) / SECTORS_PER_TRACK;
  localparam int RECIP_W  = $clog2(RECIP + 1);
  localparam int PROD_W   = TS_W + RECIP_W;

  localparam logic [OP_W-1:0] OP_POLL    = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_IRQ = 3'd1;
  localparam logic [OP_W-1:0] OP_READ    = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE   = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

  localparam logic [DRV_W-1:0] DRV_NO_MEDIA   = 3'd0;
  localparam logic [DRV_W-1:0] DRV_READY      = 3'd1;
  localparam logic [DRV_W-1:0] DRV_READY_PROT = 3'd2;
  localparam logic [DRV_W-1:0] DRV_BUSY_READ  = 3'd3;
  localparam logic [DRV_W-1:0] DRV_BUSY_WRITE = 3'd4;

  localparam logic [1:0] ST_NO_MEDIA = 2'd0;
  localparam logic [1:0] ST_BUSY     = 2'd3;

  localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BUSY       = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NO_MEDIA   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_PROTECTED  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_EJECTED    = 3'd4;
  localparam logic [ERR_W-1:0] ERR_BAD_SECTOR = 3'd5;

  localparam logic [1:0] XFER_NONE    = 2'd0;
  localparam logic [1:0] XFER_TO_MEM  = 2'd1;
  localparam logic [1:0] XFER_TO_DISK = 2'd2;

  localparam logic [1:0] STEP_CMD    = 2'd0;
  localparam logic [1:0] STEP_TRACK  = 2'd1;
  localparam logic [1:0] STEP_SECTOR = 2'd2;
  localparam logic [1:0] STEP_IDLE   = 2'd3;

  typedef struct packed {
    logic             capture;
    logic             load_target;
    logic             set_irq;
    logic             step_track;
    logic             pass_sector;
    logic             idle_rot;
    logic [1:0]       status;
    logic [ERR_W-1:0] error;
    logic             accepted;
    logic [1:0]       irq_count;
    logic             seek_valid;
    logic [1:0]       transfer;
    logic [1:0]       step_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic irq_en;
    logic sector_bad;
    logic on_track;
    logic hit;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: design/fdc_ctrl.sv
// Controller: drive state machine, error register, handshake and result control.
`timescale 1ns / 1ps
`default_nettype none

module fdc_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  input  wire logic [fdc_pkg::OP_W-1:0]   op_i,
  input  wire logic                       media_present_i,
  input  wire logic                       read_only_i,
  input  wire fdc_pkg::dp_status_t        dp_status_i,
  output fdc_pkg::dp_cmd_t                dp_cmd_o
);

  logic [fdc_pkg::DRV_W-1:0] drv_q, drv_d;
  logic [fdc_pkg::ERR_W-1:0] err_q, err_d;
  logic                      out_valid_q, out_valid_d;
  logic                      accept;
  logic                      busy;
  logic [fdc_pkg::DRV_W-1:0] ready_code;
  logic [1:0]                irq_n;
  fdc_pkg::dp_cmd_t          cmd;

  assign busy       = (drv_q == fdc_pkg::DRV_BUSY_READ) || (drv_q == fdc_pkg::DRV_BUSY_WRITE);
  assign ready_code = read_only_i ? fdc_pkg::DRV_READY_PROT : fdc_pkg::DRV_READY;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_d = accept || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd   = '0;
    drv_d = drv_q;
    err_d = err_q;
    irq_n = 2'd0;
    case (op_i)
      fdc_pkg::OP_POLL: begin
        if (media_present_i) begin
          cmd.status = busy ? fdc_pkg::ST_BUSY : drv_q[1:0];
        end
        cmd.error = err_q;
        if (err_q != fdc_pkg::ERR_NONE) begin
          irq_n = irq_n + 2'(dp_status_i.irq_en);
        end
        err_d = fdc_pkg::ERR_NONE;
      end
      fdc_pkg::OP_SET_IRQ: begin
        cmd.set_irq = 1'b1;
      end
      fdc_pkg::OP_READ, fdc_pkg::OP_WRITE: begin
        if (busy) begin
          err_d = fdc_pkg::ERR_BUSY;
        end else if (!media_present_i) begin
          err_d = fdc_pkg::ERR_NO_MEDIA;
        end else if (dp_status_i.sector_bad) begin
          err_d = fdc_pkg::ERR_BAD_SECTOR;
        end else if ((op_i == fdc_pkg::OP_WRITE) && read_only_i) begin
          err_d = fdc_pkg::ERR_PROTECTED;
        end else begin
          cmd.load_target = 1'b1;
          cmd.seek_valid  = 1'b1;
          cmd.accepted    = 1'b1;
          drv_d = (op_i == fdc_pkg::OP_READ) ? fdc_pkg::DRV_BUSY_READ
                                             : fdc_pkg::DRV_BUSY_WRITE;
          irq_n = irq_n + 2'(dp_status_i.irq_en);
        end
        if (err_d != err_q) begin
          irq_n = irq_n + 2'(dp_status_i.irq_en);
        end
        cmd.error = err_d;
      end
      fdc_pkg::OP_TICK: begin
        if (busy) begin
          if (!media_present_i) begin
            err_d = fdc_pkg::ERR_EJECTED;
            drv_d = fdc_pkg::DRV_NO_MEDIA;
            irq_n = irq_n + 2'(dp_status_i.irq_en);
          end else if (!dp_status_i.on_track) begin
            cmd.step_track = 1'b1;
            cmd.step_kind  = fdc_pkg::STEP_TRACK;
          end else begin
            cmd.pass_sector = 1'b1;
            cmd.step_kind   = fdc_pkg::STEP_SECTOR;
            if (dp_status_i.hit) begin
              cmd.transfer = (drv_q == fdc_pkg::DRV_BUSY_READ) ? fdc_pkg::XFER_TO_MEM
                                                               : fdc_pkg::XFER_TO_DISK;
              drv_d = ready_code;
              irq_n = irq_n + 2'(dp_status_i.irq_en);
            end
          end
        end else begin
          if (!media_present_i) begin
            if (drv_q != fdc_pkg::DRV_NO_MEDIA) begin
              drv_d = fdc_pkg::DRV_NO_MEDIA;
              irq_n = irq_n + 2'(dp_status_i.irq_en);
            end
          end else if (drv_q == fdc_pkg::DRV_NO_MEDIA) begin
            drv_d = ready_code;
            irq_n = irq_n + 2'(dp_status_i.irq_en);
          end
          cmd.idle_rot  = 1'b1;
          cmd.step_kind = fdc_pkg::STEP_IDLE;
        end
      end
      default: begin
      end
    endcase
    cmd.irq_count = irq_n;
    cmd.capture   = accept;
  end

  assign dp_cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_q       <= fdc_pkg::DRV_NO_MEDIA;
      err_q       <= fdc_pkg::ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        drv_q <= drv_d;
        err_q <= err_d;
      end
    end
  end

  a_transfer_leaves_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item left no pending result");

  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd.accepted |=>
      (drv_q == fdc_pkg::DRV_BUSY_READ) || (drv_q == fdc_pkg::DRV_BUSY_WRITE))
    else $error("started command did not make the drive busy");

  a_poll_clears_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i == fdc_pkg::OP_POLL) |=> err_q == fdc_pkg::ERR_NONE)
    else $error("poll did not clear the error");

  a_eject_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i == fdc_pkg::OP_TICK) && busy && !media_present_i |=>
      (drv_q == fdc_pkg::DRV_NO_MEDIA) && (err_q == fdc_pkg::ERR_EJECTED))
    else $error("eject during a transfer not handled");

endmodule

`default_nettype wire

FILE: design/fdc_datapath.sv
// Datapath: head position, target registers, interrupt message and result register.
`timescale 1ns / 1ps
`default_nettype none

module fdc_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fdc_pkg::dp_cmd_t              dp_cmd_i,
  output fdc_pkg::dp_status_t                dp_status_o,
  input  wire logic [fdc_pkg::WORD_W-1:0]    sector_arg_i,
  input  wire logic [fdc_pkg::WORD_W-1:0]    mem_addr_i,
  input  wire logic [fdc_pkg::WORD_W-1:0]    int_word_i,
  input  wire logic [fdc_pkg::BLOCK_W-1:0]   disk_index_i,
  output logic [1:0]                         status_o,
  output logic [fdc_pkg::ERR_W-1:0]          error_o,
  output logic                               accepted_o,
  output logic [1:0]                         irq_count_o,
  output logic [fdc_pkg::WORD_W-1:0]         irq_message_o,
  output logic                               seek_valid_o,
  output logic [fdc_pkg::BLOCK_W-1:0]        seek_block_o,
  output logic [1:0]                         transfer_o,
  output logic [fdc_pkg::WORD_W-1:0]         transfer_addr_o,
  output logic [1:0]                         transfer_offset_o,
  output logic [1:0]                         step_kind_o
);

  localparam logic [fdc_pkg::HS_W:0] SPT = (fdc_pkg::HS_W + 1)'(fdc_pkg::SECTORS_PER_TRACK);

  logic [fdc_pkg::TRACK_W-1:0] head_track_q, head_track_d;
  logic [fdc_pkg::HS_W-1:0]    head_sector_q, head_sector_d;
  logic [fdc_pkg::TS_W-1:0]    target_sector_q;
  logic [fdc_pkg::TT_W-1:0]    target_track_q;
  logic [fdc_pkg::WORD_W-1:0]  xfer_address_q;
  logic [fdc_pkg::WORD_W-1:0]  irq_value_q, irq_value_d;

  logic [fdc_pkg::PROD_W-1:0]  track_prod;
  logic [fdc_pkg::TT_W-1:0]    track_calc;
  logic [fdc_pkg::TS_W-1:0]    track_base;
  logic [fdc_pkg::HS_W-1:0]    target_rot;
  logic [fdc_pkg::HS_W:0]      hs_sum;
  logic [fdc_pkg::HS_W:0]      hs_add;
  logic [fdc_pkg::TRACK_W-1:0] tt_ext;

  logic [1:0]                  status_q;
  logic [fdc_pkg::ERR_W-1:0]   error_q;
  logic                        accepted_q;
  logic [1:0]                  irq_count_q;
  logic                        seek_valid_q;
  logic [fdc_pkg::BLOCK_W-1:0] seek_block_q;
  logic [1:0]                  transfer_q;
  logic [fdc_pkg::WORD_W-1:0]  transfer_addr_q;
  logic [1:0]                  transfer_offset_q;
  logic [1:0]                  step_kind_q;

  // Track number by reciprocal multiplication; exact for every sector below the total.
  assign track_prod = fdc_pkg::PROD_W'(sector_arg_i[fdc_pkg::TS_W-1:0])
                    * fdc_pkg::PROD_W'(fdc_pkg::RECIP);
  assign track_calc = fdc_pkg::TT_W'(track_prod >> fdc_pkg::RECIP_SH);

  assign track_base = fdc_pkg::TS_W'(target_track_q * fdc_pkg::TS_W'(fdc_pkg::SECTORS_PER_TRACK));
  assign target_rot = fdc_pkg::HS_W'(target_sector_q - track_base);

  assign tt_ext = fdc_pkg::TRACK_W'(target_track_q);

  always_comb begin
    hs_add = '0;
    if (dp_cmd_i.step_track) begin
      hs_add = (fdc_pkg::HS_W + 1)'(fdc_pkg::STEP_ADV);
    end else if (dp_cmd_i.pass_sector) begin
      hs_add = (fdc_pkg::HS_W + 1)'(1 % fdc_pkg::SECTORS_PER_TRACK);
    end else if (dp_cmd_i.idle_rot) begin
      hs_add = (fdc_pkg::HS_W + 1)'(fdc_pkg::IDLE_ADV);
    end
    hs_sum = {1'b0, head_sector_q} + hs_add;
    if (hs_sum >= SPT) begin
      hs_sum = hs_sum - SPT;
    end
    head_sector_d = hs_sum[fdc_pkg::HS_W-1:0];
  end

  always_comb begin
    head_track_d = head_track_q;
    if (dp_cmd_i.step_track) begin
      if (tt_ext < head_track_q) begin
        head_track_d = head_track_q - fdc_pkg::TRACK_W'(1);
      end else begin
        head_track_d = head_track_q + fdc_pkg::TRACK_W'(1);
      end
    end
  end

  assign irq_value_d = dp_cmd_i.set_irq ? int_word_i : irq_value_q;

  // The target sector is under the head exactly when the head now sits on it and the disk index matches its block.
  assign dp_status_o.irq_en     = irq_value_q != '0;
  assign dp_status_o.sector_bad = sector_arg_i >= fdc_pkg::WORD_W'(fdc_pkg::TOTAL_SECTORS);
  assign dp_status_o.on_track   = tt_ext == head_track_q;
  assign dp_status_o.hit        = (head_sector_q == target_rot) &&
                                  (disk_index_i ==
                                   fdc_pkg::BLOCK_W'(target_sector_q >> 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_track_q    <= fdc_pkg::HEAD_TRACK_RESET;
      head_sector_q   <= '0;
      target_sector_q <= '0;
      target_track_q  <= '0;
      xfer_address_q  <= '0;
      irq_value_q     <= '0;
    end else if (dp_cmd_i.capture) begin
      head_track_q  <= head_track_d;
      head_sector_q <= head_sector_d;
      irq_value_q   <= irq_value_d;
      if (dp_cmd_i.load_target) begin
        target_sector_q <= sector_arg_i[fdc_pkg::TS_W-1:0];
        target_track_q  <= track_calc;
        xfer_address_q  <= mem_addr_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) begin
      status_q        <= dp_cmd_i.status;
      error_q         <= dp_cmd_i.error;
      accepted_q      <= dp_cmd_i.accepted;
      irq_count_q     <= dp_cmd_i.irq_count;
      seek_valid_q    <= dp_cmd_i.seek_valid;
      seek_block_q    <= dp_cmd_i.seek_valid ? sector_arg_i[fdc_pkg::BLOCK_W+1:2] : '0;
      transfer_q      <= dp_cmd_i.transfer;
      transfer_addr_q <= (dp_cmd_i.transfer == fdc_pkg::XFER_TO_MEM) ? xfer_address_q : '0;
      transfer_offset_q <= (dp_cmd_i.transfer != fdc_pkg::XFER_NONE) ?
                           target_sector_q[1:0] : 2'd0;
      step_kind_q     <= dp_cmd_i.step_kind;
    end
  end

  assign status_o          = status_q;
  assign error_o           = error_q;
  assign accepted_o        = accepted_q;
  assign irq_count_o       = irq_count_q;
  assign irq_message_o     = irq_value_q;
  assign seek_valid_o      = seek_valid_q;
  assign seek_block_o      = seek_block_q;
  assign transfer_o        = transfer_q;
  assign transfer_addr_o   = transfer_addr_q;
  assign transfer_offset_o = transfer_offset_q;
  assign step_kind_o       = step_kind_q;

endmodule

`default_nettype wire

FILE: design/floppy_drive_controller_unit.sv
// Top level of the sector-addressed floppy drive controller.
`timescale 1ns / 1ps
`default_nettype none

// Each input item (a command or a mechanical tick) is taken when valid and ready meet, and
// its single result appears in the output register on the next cycle. A new item is
// accepted whenever the output register is empty or its result is being taken in
// the same cycle, so the block sustains one item per cycle; the output register is
// the only thing that holds it back. The interrupt message output always shows the
// stored message after the item. There is no clearing pass after reset.
module floppy_drive_controller_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [fdc_pkg::OP_W-1:0]      op_i,
  input  wire logic                          media_present_i,
  input  wire logic                          read_only_i,
  input  wire logic [fdc_pkg::WORD_W-1:0]    sector_arg_i,
  input  wire logic [fdc_pkg::WORD_W-1:0]    mem_addr_i,
  input  wire logic [fdc_pkg::WORD_W-1:0]    int_word_i,
  input  wire logic [fdc_pkg::BLOCK_W-1:0]   disk_index_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         status_o,
  output logic [fdc_pkg::ERR_W-1:0]          error_o,
  output logic                               accepted_o,
  output logic [1:0]                         irq_count_o,
  output logic [fdc_pkg::WORD_W-1:0]         irq_message_o,
  output logic                               seek_valid_o,
  output logic [fdc_pkg::BLOCK_W-1:0]        seek_block_o,
  output logic [1:0]                         transfer_o,
  output logic [fdc_pkg::WORD_W-1:0]         transfer_addr_o,
  output logic [1:0]                         transfer_offset_o,
  output logic [1:0]                         step_kind_o
);

  fdc_pkg::dp_cmd_t    dp_cmd;
  fdc_pkg::dp_status_t dp_status;

  fdc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .op_i            (op_i),
    .media_present_i (media_present_i),
    .read_only_i     (read_only_i),
    .dp_status_i     (dp_status),
    .dp_cmd_o        (dp_cmd)
  );

  fdc_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .dp_cmd_i          (dp_cmd),
    .dp_status_o       (dp_status),
    .sector_arg_i      (sector_arg_i),
    .mem_addr_i        (mem_addr_i),
    .int_word_i        (int_word_i),
    .disk_index_i      (disk_index_i),
    .status_o          (status_o),
    .error_o           (error_o),
    .accepted_o        (accepted_o),
    .irq_count_o       (irq_count_o),
    .irq_message_o     (irq_message_o),
    .seek_valid_o      (seek_valid_o),
    .seek_block_o      (seek_block_o),
    .transfer_o        (transfer_o),
    .transfer_addr_o   (transfer_addr_o),
    .transfer_offset_o (transfer_offset_o),
    .step_kind_o       (step_kind_o)
  );

endmodule

`default_nettype wire
